// ----- sv/pvp_pkg.sv -----
// Shared widths, register indexes and latencies for the perspective vertex projector.
`timescale 1ns / 1ps

package pvp_pkg;

  localparam int NUM_W   = 48;
  localparam int DEN_W   = 33;
  localparam int QBITS   = 15;
  localparam int DIV_LAT = QBITS + 1;
  localparam int FRONT_LAT = 5;

  localparam logic [2:0] REG_COS    = 3'd0;
  localparam logic [2:0] REG_SIN    = 3'd1;
  localparam logic [2:0] REG_DEPTH  = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  typedef logic [NUM_W-1:0] mag_t;
  typedef logic [DEN_W-1:0] den_t;

endpackage

// ----- sv/pvp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturated to 16 bits.
`timescale 1ns / 1ps

module pvp_div (
  input  logic               clk,
  input  logic               en,
  input  pvp_pkg::mag_t      mag,
  input  logic               neg,
  input  pvp_pkg::den_t      den,
  output logic signed [15:0] quot
);

  localparam int QB = pvp_pkg::QBITS;
  localparam int NW = pvp_pkg::NUM_W;
  localparam int DW = pvp_pkg::DEN_W;

  pvp_pkg::mag_t  rem   [0:QB];
  pvp_pkg::den_t  dvs   [0:QB];
  logic [QB-1:0]  qbits [0:QB];
  logic           sgn   [0:QB];
  logic           ovf   [0:QB];

  // overflow when the quotient would reach 2^15
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= mag;
      dvs[0]   <= den;
      qbits[0] <= '0;
      sgn[0]   <= neg;
      ovf[0]   <= (mag >= {den, {QB{1'b0}}});
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int BIT = QB - j;
    pvp_pkg::mag_t trial;
    assign trial = {{(NW-DW){1'b0}}, dvs[j-1]} << BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        dvs[j] <= dvs[j-1];
        sgn[j] <= sgn[j-1];
        ovf[j] <= ovf[j-1];
        if (rem[j-1] >= trial) begin
          rem[j]   <= rem[j-1] - trial;
          qbits[j] <= qbits[j-1] | (QB'(1) << BIT);
        end else begin
          rem[j]   <= rem[j-1];
          qbits[j] <= qbits[j-1];
        end
      end
    end
  end

  logic signed [15:0] q_pos;
  assign q_pos = $signed({1'b0, qbits[QB]});

  always_comb begin
    if (ovf[QB]) begin
      quot = sgn[QB] ? 16'sh8000 : 16'sh7fff;
    end else begin
      quot = sgn[QB] ? -q_pos : q_pos;
    end
  end

endmodule

// ----- sv/perspective_vertex_project_top.sv -----
// Top level of the perspective vertex projector: registers, datapath and handshake.
// One vertex per clock is accepted and one result per clock delivered while the output is not
// stalled. From input transfer to result a vertex passes five stages for the rotation products,
// depth, numerator products, numerator sums and sign split, sixteen stages of the
// pipelined restoring divider (overflow check, then one quotient bit per stage) that
// forms both screen coordinates in parallel, and the output register. A stall at the
// output holds the whole pipeline while a result waits. Configuration writes are always
// ready and take effect on the next cycle; write them only while no vertex is in flight.
`timescale 1ns / 1ps

module perspective_vertex_project_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] vertex_x,
  input  logic signed [15:0] vertex_y,
  input  logic signed [15:0] vertex_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  output logic               behind_camera,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NST = pvp_pkg::FRONT_LAT + pvp_pkg::DIV_LAT;

  logic signed [15:0] cos_angle;
  logic signed [15:0] sin_angle;
  logic [14:0]        depth_offset;
  logic [12:0]        screen_width;
  logic [12:0]        screen_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle     <= 16'sd16384;
      sin_angle     <= 16'sd0;
      depth_offset  <= 15'd3840;
      screen_width  <= 13'd640;
      screen_height <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pvp_pkg::REG_COS:    cos_angle     <= $signed(cfg_data);
        pvp_pkg::REG_SIN:    sin_angle     <= $signed(cfg_data);
        pvp_pkg::REG_DEPTH:  depth_offset  <= cfg_data[14:0];
        pvp_pkg::REG_WIDTH:  screen_width  <= cfg_data[12:0];
        pvp_pkg::REG_HEIGHT: screen_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [NST-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[NST-2:0], in_valid};
    end
  end

  logic signed [13:0] w_s;
  logic signed [13:0] h_s;
  assign w_s = $signed({1'b0, screen_width});
  assign h_s = $signed({1'b0, screen_height});

  // s1: rotation products
  logic signed [31:0] p_xc, p_zs, p_xs, p_zc;
  logic signed [15:0] y1;
  // s2: rotated x and depth
  logic signed [32:0] rx2;
  logic signed [33:0] d2;
  logic signed [15:0] y2;
  // s3: numerator products
  logic signed [47:0] mxh3, mdw3, mdh3;
  logic signed [29:0] myh3;
  pvp_pkg::den_t      den3;
  logic               bh3;
  // s4: numerators
  logic signed [47:0] nx4, ny4;
  pvp_pkg::den_t      den4;
  logic               bh4;
  // s5: sign and magnitude
  pvp_pkg::mag_t      magx5, magy5;
  logic               negx5, negy5;
  pvp_pkg::den_t      den5;
  logic               bh5;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= vertex_x * cos_angle;
      p_zs <= vertex_z * sin_angle;
      p_xs <= vertex_x * sin_angle;
      p_zc <= vertex_z * cos_angle;
      y1   <= vertex_y;

      rx2 <= p_xc - p_zs;
      d2  <= p_xs + p_zc + $signed({5'b0, depth_offset, 14'b0});
      y2  <= y1;

      mxh3 <= rx2 * h_s;
      mdw3 <= d2 * w_s;
      mdh3 <= d2 * h_s;
      myh3 <= y2 * h_s;
      den3 <= {d2[31:0], 1'b0};
      bh3  <= (d2 <= 34'sd0);

      nx4  <= mxh3 + mdw3;
      ny4  <= mdh3 - $signed({{4{myh3[29]}}, myh3, 14'b0});
      den4 <= den3;
      bh4  <= bh3;

      negx5 <= nx4[47];
      negy5 <= ny4[47];
      magx5 <= nx4[47] ? $unsigned(-nx4) : $unsigned(nx4);
      magy5 <= ny4[47] ? $unsigned(-ny4) : $unsigned(ny4);
      den5  <= den4;
      bh5   <= bh4;
    end
  end

  logic signed [15:0] qx, qy;

  pvp_div u_div_x (
    .clk  (clk),
    .en   (en),
    .mag  (magx5),
    .neg  (negx5),
    .den  (den5),
    .quot (qx)
  );

  pvp_div u_div_y (
    .clk  (clk),
    .en   (en),
    .mag  (magy5),
    .neg  (negy5),
    .den  (den5),
    .quot (qy)
  );

  logic [pvp_pkg::DIV_LAT-1:0] bh_pipe;

  always_ff @(posedge clk) begin
    if (en) begin
      bh_pipe <= {bh_pipe[pvp_pkg::DIV_LAT-2:0], bh5};
    end
  end

  logic bh_last;
  assign bh_last = bh_pipe[pvp_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vpipe[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      behind_camera <= bh_last;
      screen_x      <= bh_last ? 16'sd0 : qx;
      screen_y      <= bh_last ? 16'sd0 : qy;
    end
  end

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && behind_camera) |-> (screen_x == 16'sd0 && screen_y == 16'sd0))
    else $error("behind-camera result with nonzero coordinates");

  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(vpipe) && out_valid))
    else $error("pipeline moved during output stall");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    (en && vpipe[NST-1]) |=> out_valid)
    else $error("item lost between divider and output register");

  a_stall_only_on_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the perspective vertex projector: stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               behind;
  } pixel_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = pvp_pkg::FRONT_LAT + pvp_pkg::DIV_LAT + 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] vertex_x = '0;
  logic signed [15:0] vertex_y = '0;
  logic signed [15:0] vertex_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic               behind_camera;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // register shadow
  logic signed [15:0] cam_cos   = 16'sd16384;
  logic signed [15:0] cam_sin   = 16'sd0;
  logic [14:0]        cam_depth = 15'd3840;
  logic [12:0]        view_w    = 13'd640;
  logic [12:0]        view_h    = 13'd480;

  pixel_t expected_pixels[$];

  int mismatches     = 0;
  int vertices_sent  = 0;
  int pixels_seen    = 0;
  int behind_count   = 0;
  int setting_count  = 1;
  int idle_cycles    = 0;
  int hold_len       = 0;
  bit stall_en       = 1'b0;
  bit gap_en         = 1'b0;

  perspective_vertex_project_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .vertex_z      (vertex_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .screen_x      (screen_x),
    .screen_y      (screen_y),
    .behind_camera (behind_camera),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Q8.8 vertex x Q1.14 rotation gives Q.22; screen_x scales by the height and adds half the width
  function automatic pixel_t project_vertex(logic signed [15:0] x, logic signed [15:0] y,
                                            logic signed [15:0] z);
    longint rx, rz, depth, w, h, den;
    pixel_t p;
    w = longint'(view_w);
    h = longint'(view_h);
    rx = longint'(x) * longint'(cam_cos) - longint'(z) * longint'(cam_sin);
    rz = longint'(x) * longint'(cam_sin) + longint'(z) * longint'(cam_cos);
    depth = rz + longint'(cam_depth) * 16384;
    p.behind = (depth <= 0);
    if (p.behind) begin
      p.sx = '0;
      p.sy = '0;
    end else begin
      den = 2 * depth;
      p.sx = clamp16((rx * h + w * depth) / den);
      p.sy = clamp16((h * depth - longint'(y) * 16384 * h) / den);
    end
    return p;
  endfunction

  task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
    int gap;
    pixel_t p;
    gap = gap_en ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    vertex_x <= x;
    vertex_y <= y;
    vertex_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = project_vertex(x, y, z);
    expected_pixels.push_back(p);
    vertices_sent++;
    if (p.behind) behind_count++;
  endtask

  task automatic send_random_vertex();
    int sel;
    int zv;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      send_vertex(16'($urandom), 16'($urandom), 16'($urandom));
    end else if (sel < 8) begin
      send_vertex(16'($urandom_range(0, 4095) - 2048),
                  16'($urandom_range(0, 4095) - 2048),
                  16'($urandom_range(0, 4095) - 2048));
    end else begin
      zv = -int'(cam_depth) + $urandom_range(0, 16) - 8;
      send_vertex(16'($urandom_range(0, 63) - 32), 16'($urandom_range(0, 63) - 32),
                  16'(zv));
    end
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pvp_pkg::REG_COS:    cam_cos   = data;
      pvp_pkg::REG_SIN:    cam_sin   = data;
      pvp_pkg::REG_DEPTH:  cam_depth = data[14:0];
      pvp_pkg::REG_WIDTH:  view_w    = data[12:0];
      pvp_pkg::REG_HEIGHT: view_h    = data[12:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [15:0] c, input logic [15:0] s,
                                input logic [15:0] depth, input logic [15:0] w,
                                input logic [15:0] h);
    write_reg(pvp_pkg::REG_COS, c);
    write_reg(pvp_pkg::REG_SIN, s);
    write_reg(pvp_pkg::REG_DEPTH, depth);
    write_reg(pvp_pkg::REG_WIDTH, w);
    write_reg(pvp_pkg::REG_HEIGHT, h);
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
    send_vertex(16'sh7FFF, 16'sh8000, 16'sd0);
    send_vertex(16'sh8000, 16'sh7FFF, 16'sd0);
    send_vertex(16'sd0, 16'sd0, -16'sd3840);
    send_vertex(16'sd0, 16'sd0, -16'sd3839);
    send_vertex(16'sd256, 16'sd256, -16'sd3839);
    send_vertex(-16'sd256, -16'sd256, -16'sd3839);
    send_vertex(16'sd1, -16'sd1, 16'sd0);
    send_vertex(16'sh5555, 16'shAAAA, 16'sh5555);
    send_vertex(16'shAAAA, 16'sh5555, 16'shAAAA);
    wait_idle();
  endtask

  task automatic test_corner_settings();
    logic [15:0] corner [6][5];
    corner = '{
      '{16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0000, 16'h4000, 16'hFFFF, 16'hFFFF, 16'h1FFF},
      '{16'h7FFF, 16'h8000, 16'h0001, 16'h0001, 16'h0001},
      '{16'h8000, 16'h7FFF, 16'h0F00, 16'h1000, 16'h1000},
      '{16'h4000, 16'hC000, 16'h0100, 16'h0000, 16'h01E0},
      '{16'h2D41, 16'h2D41, 16'h7FFF, 16'h0280, 16'h0000}
    };
    gap_en   = 1'b1;
    stall_en = 1'b1;
    foreach (corner[i]) begin
      write_settings(corner[i][0], corner[i][1], corner[i][2], corner[i][3], corner[i][4]);
      send_vertex(16'sd0, 16'sd0, 16'sd1);
      send_vertex(16'sh7FFF, 16'sh8000, 16'sh8000);
      repeat (20) send_random_vertex();
      wait_idle();
    end
  endtask

  task automatic test_ignored_index();
    gap_en   = 1'b1;
    stall_en = 1'b1;
    write_settings(16'h4000, 16'h0000, 16'h0F00, 16'h0280, 16'h01E0);
    @(posedge clk);
    write_reg(3'd5, 16'($urandom));
    write_reg(3'd6, 16'($urandom));
    write_reg(3'd7, 16'hFFFF);
    cfg_valid <= 1'b0;
    repeat (8) send_random_vertex();
    wait_idle();
  endtask

  task automatic test_backpressure();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    hold_len = 300;
    repeat (100) send_random_vertex();
    wait_idle();
  endtask

  task automatic test_random();
    logic [15:0] c, s, depth, w, h;
    for (int phase = 0; phase < 15; phase++) begin
      c = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
      s = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
      case ($urandom_range(0, 3))
        0:       depth = 16'($urandom_range(0, 4095));
        1:       depth = 16'($urandom);
        default: depth = 16'($urandom_range(0, 32767));
      endcase
      w = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
      h = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
      write_settings(c, s, depth, w, h);
      gap_en   = (phase % 4 != 1);
      stall_en = (phase % 4 != 2);
      repeat (100) send_random_vertex();
      wait_idle();
    end
  endtask

  // output stall generator
  initial begin : stall_gen
    int n;
    bit level;
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else if (!stall_en) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        level = ($urandom_range(0, 1) == 1);
        out_stall <= level;
        n = level ? idle_len() : $urandom_range(1, 8);
        repeat (n > 0 ? n : 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t exp_p;
    if (!rst && out_valid && !out_stall) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: x=%0d y=%0d behind=%0b",
                   screen_x, screen_y, behind_camera);
      end else begin
        exp_p = expected_pixels.pop_front();
        if (screen_x !== exp_p.sx || screen_y !== exp_p.sy ||
            behind_camera !== exp_p.behind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: expected x=%0d y=%0d behind=%0b, ",
                     pixels_seen, exp_p.sx, exp_p.sy, exp_p.behind,
                     "got x=%0d y=%0d behind=%0b",
                     screen_x, screen_y, behind_camera);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_corner_settings();
    test_ignored_index();
    test_backpressure();
    test_random();
    mismatches += expected_pixels.size();
    $display("Projected %0d vertices under %0d register settings, %0d behind the camera.",
             vertices_sent, setting_count, behind_count);
    $display("Random gaps and stalls on both sides, plus one long output hold-off.");
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
sv/pvp_pkg.sv
sv/pvp_div.sv
sv/perspective_vertex_project_top.sv
test/tb_top.sv
